@@ rtl/core/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the mixed-radix index converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  localparam int unsigned IndexWidth = 32;
  localparam int unsigned CoordWidth = 10;
  localparam int unsigned ExtWidth   = 11;
  localparam int unsigned SubWidth   = 3;
  localparam int unsigned DimsWidth  = 3;
  localparam int unsigned SubCntWidth = 4;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned NumMacSteps = 4;
  localparam int unsigned DivSteps   = IndexWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgNumDims    = 3'd0,
    CfgLengthDim1 = 3'd1,
    CfgLengthDim2 = 3'd2,
    CfgLengthDim3 = 3'd3,
    CfgSubCount   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OpToIndex = 1'b0,
    OpToCoord = 1'b1
  } op_e;

  typedef struct packed {
    logic                  op;
    logic [CoordWidth-1:0] coord_in_0;
    logic [CoordWidth-1:0] coord_in_1;
    logic [CoordWidth-1:0] coord_in_2;
    logic [CoordWidth-1:0] coord_in_3;
    logic [SubWidth-1:0]   sub_in;
    logic [IndexWidth-1:0] index_in;
  } in_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] index_out;
    logic [IndexWidth-1:0] coord_out_0;
    logic [CoordWidth-1:0] coord_out_1;
    logic [CoordWidth-1:0] coord_out_2;
    logic [CoordWidth-1:0] coord_out_3;
    logic [SubWidth-1:0]   sub_out;
  } out_item_t;

  // one slot of the cell chain
  typedef struct packed {
    logic                  valid;
    logic                  op;
    logic [IndexWidth-1:0] n;
    logic [ExtWidth-1:0]   rem;
    logic [CoordWidth-1:0] c1;
    logic [CoordWidth-1:0] c2;
    logic [CoordWidth-1:0] c3;
    logic [SubWidth-1:0]   sub;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/mrc_div_cell.sv @@
// ----------------------------------------------------------------------------
// mrc_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_div_cell import mrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [ExtWidth-1:0] div_i,
  input  stage_t              st_i,
  output stage_t              st_o
);

  stage_t            st_d, st_q;
  logic [ExtWidth:0] trial;
  logic [ExtWidth:0] diff;
  logic              ge;

  always_comb begin
    trial = {st_i.rem, st_i.n[IndexWidth-1]};
    diff  = trial - {1'b0, div_i};
    ge    = (trial >= {1'b0, div_i});
    st_d  = st_i;
    if (st_i.op == OpToCoord) begin
      st_d.n   = {st_i.n[IndexWidth-2:0], ge};
      st_d.rem = ge ? diff[ExtWidth-1:0] : trial[ExtWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

`default_nettype wire

@@ rtl/core/mrc_digit.sv @@
// ----------------------------------------------------------------------------
// mrc_digit
// Row of division cells that splits off one digit of the index.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_digit import mrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [ExtWidth-1:0] div_i,
  input  stage_t              st_i,
  output stage_t              st_o
);

  stage_t chain [DivSteps+1];

  assign chain[0] = st_i;

  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    mrc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .div_i  (div_i),
      .st_i   (chain[k]),
      .st_o   (chain[k+1])
    );
  end

  assign st_o = chain[DivSteps];

endmodule

`default_nettype wire

@@ rtl/core/mrc_mac_cell.sv @@
// ----------------------------------------------------------------------------
// mrc_mac_cell
// One multiply-add step of the coordinates to index direction.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_mac_cell import mrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [ExtWidth-1:0]   mul_i,
  input  logic [CoordWidth-1:0] add_i,
  input  stage_t                st_i,
  output stage_t                st_o
);

  stage_t                         st_d, st_q;
  logic [IndexWidth+ExtWidth-1:0] prod;

  always_comb begin
    prod = st_i.n * mul_i;
    st_d = st_i;
    if (st_i.op == OpToIndex) begin
      st_d.n = prod[IndexWidth-1:0] + {{(IndexWidth-CoordWidth){1'b0}}, add_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule

`default_nettype wire

@@ rtl/core/mixed_radix_index_convert_core.sv @@
// ----------------------------------------------------------------------------
// mixed_radix_index_convert_core
// Lattice coordinates to linear site index and back, one item per cycle.
// ----------------------------------------------------------------------------
// Every item runs through one fixed chain of cells: 4 multiply-add cells
// (coordinates to index), then 4 rows of 32 restoring division cells (index
// to coordinates, one quotient bit per cell, dividing by the sublattice
// count, then L3, L2, L1), then an output register. Items of either
// direction pass the cells of the other unchanged. A new item is taken
// every cycle while the output side takes results; a stall on the output
// freezes the whole chain. Configuration may only be written while the
// chain is empty.
`default_nettype none

module mixed_radix_index_convert_core import mrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ExtWidth-1:0]    cfg_wdata_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o
);

  // configuration registers
  logic [DimsWidth-1:0]   num_dims_q;
  logic [ExtWidth-1:0]    len1_q, len2_q, len3_q;
  logic [SubCntWidth-1:0] sub_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= DimsWidth'(2);
      len1_q     <= ExtWidth'(16);
      len2_q     <= ExtWidth'(1);
      len3_q     <= ExtWidth'(1);
      sub_cnt_q  <= SubCntWidth'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumDims:    num_dims_q <= cfg_wdata_i[DimsWidth-1:0];
        CfgLengthDim1: len1_q     <= cfg_wdata_i;
        CfgLengthDim2: len2_q     <= cfg_wdata_i;
        CfgLengthDim3: len3_q     <= cfg_wdata_i;
        CfgSubCount:   sub_cnt_q  <= cfg_wdata_i[SubCntWidth-1:0];
        default: ;
      endcase
    end
  end

  // effective radices: zero reads as one, dimensions not in use get radix one
  logic                use1, use2, use3;
  logic [ExtWidth-1:0] ext1, ext2, ext3, ext_sub;

  always_comb begin
    // dimension count 0 acts as 1, anything above 4 acts as 4
    use1 = (num_dims_q >= DimsWidth'(2));
    use2 = (num_dims_q >= DimsWidth'(3));
    use3 = (num_dims_q >= DimsWidth'(4));
    ext1 = (use1 && len1_q != '0) ? len1_q : ExtWidth'(1);
    ext2 = (use2 && len2_q != '0) ? len2_q : ExtWidth'(1);
    ext3 = (use3 && len3_q != '0) ? len3_q : ExtWidth'(1);
    ext_sub = (sub_cnt_q != '0) ? {{(ExtWidth-SubCntWidth){1'b0}}, sub_cnt_q}
                                : ExtWidth'(1);
  end

  // chain advances whenever the output register is free or being emptied
  logic      adv;
  stage_t    out_q;
  logic      out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // load slot: unused coordinates enter as zero so their step adds nothing
  stage_t load;

  always_comb begin
    load       = '0;
    load.valid = in_valid_i;
    load.op    = in_item_i.op;
    if (in_item_i.op == OpToCoord) begin
      load.n = in_item_i.index_in;
    end else begin
      load.n   = {{(IndexWidth-CoordWidth){1'b0}}, in_item_i.coord_in_0};
      load.c1  = use1 ? in_item_i.coord_in_1 : '0;
      load.c2  = use2 ? in_item_i.coord_in_2 : '0;
      load.c3  = use3 ? in_item_i.coord_in_3 : '0;
      load.sub = in_item_i.sub_in;
    end
  end

  // multiply-add cells: acc = (((c0*L1 + c1)*L2 + c2)*L3 + c3)*S + sub
  stage_t                mac [NumMacSteps+1];
  logic [ExtWidth-1:0]   mac_mul [NumMacSteps];
  logic [CoordWidth-1:0] mac_add [NumMacSteps];

  assign mac[0] = load;

  always_comb begin
    mac_mul[0] = ext1;
    mac_mul[1] = ext2;
    mac_mul[2] = ext3;
    mac_mul[3] = ext_sub;
    mac_add[0] = mac[0].c1;
    mac_add[1] = mac[1].c2;
    mac_add[2] = mac[2].c3;
    mac_add[3] = {{(CoordWidth-SubWidth){1'b0}}, mac[3].sub};
  end

  for (genvar m = 0; m < NumMacSteps; m++) begin : g_mac
    mrc_mac_cell u_mac (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .mul_i  (mac_mul[m]),
      .add_i  (mac_add[m]),
      .st_i   (mac[m]),
      .st_o   (mac[m+1])
    );
  end

  // division rows: sublattice digit first, then dimensions 3, 2, 1
  stage_t              dig_in  [NumDigits+1];
  stage_t              dig_raw [NumDigits];
  logic [ExtWidth-1:0] dig_div [NumDigits];

  assign dig_in[0] = mac[NumMacSteps];

  always_comb begin
    dig_div[0] = ext_sub;
    dig_div[1] = ext3;
    dig_div[2] = ext2;
    dig_div[3] = ext1;
  end

  for (genvar g = 0; g < NumDigits; g++) begin : g_digit
    mrc_digit u_digit (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .div_i  (dig_div[g]),
      .st_i   (dig_in[g]),
      .st_o   (dig_raw[g])
    );

    // park the remainder in its digit field and restart it for the next row
    always_comb begin
      dig_in[g+1]     = dig_raw[g];
      dig_in[g+1].rem = '0;
      if (dig_raw[g].op == OpToCoord) begin
        if (g == 0) begin
          dig_in[g+1].sub = dig_raw[g].rem[SubWidth-1:0];
        end else if (g == 1) begin
          dig_in[g+1].c3 = dig_raw[g].rem[CoordWidth-1:0];
        end else if (g == 2) begin
          dig_in[g+1].c2 = dig_raw[g].rem[CoordWidth-1:0];
        end else begin
          dig_in[g+1].c1 = dig_raw[g].rem[CoordWidth-1:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (adv) begin
      out_valid_q <= dig_in[NumDigits].valid;
      out_q       <= dig_in[NumDigits];
    end
  end

  // fields of the other direction read zero
  always_comb begin
    out_item_o = '0;
    if (out_q.op == OpToCoord) begin
      out_item_o.coord_out_0 = out_q.n;
      out_item_o.coord_out_1 = out_q.c1;
      out_item_o.coord_out_2 = out_q.c2;
      out_item_o.coord_out_3 = out_q.c3;
      out_item_o.sub_out     = out_q.sub;
    end else begin
      out_item_o.index_out = out_q.n;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
